// ===== rtl/lbf_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lbf_pkg
// Shared codes, reset values and types of the LED burst flasher.
// ---------------------------------------------------------------------------
package lbf_pkg;

  localparam int LBF_TIME_BITS  = 16;
  localparam int CFG_TIME_W     = 16;
  localparam int CFG_INDEX_W    = 2;
  localparam int CFG_DATA_W     = 16;
  localparam int CMD_W          = 2;
  localparam int COUNT_W        = 16;
  localparam int BURST_W        = 8;

  // command codes
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_ON_TIME  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OFF_TIME = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_INVERT   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ENABLE   = 2'd3;

  // reset values and limits
  localparam logic [CFG_TIME_W-1:0] RESET_ON_TIME  = 16'd20;
  localparam logic [CFG_TIME_W-1:0] RESET_OFF_TIME = 16'd200;
  localparam logic                  RESET_INVERT   = 1'b1;
  localparam logic                  RESET_ENABLE   = 1'b0;
  localparam logic [COUNT_W-1:0]    BURST_LIMIT    = 16'h00ff;

  typedef struct packed {
    logic [CFG_TIME_W-1:0] on_time;
    logic [CFG_TIME_W-1:0] dark_time;
    logic                  invert_output;
    logic                  enable;
  } lbf_cfg_t;

  typedef struct packed {
    logic pin_level;
    logic lit;
    logic busy;
  } lbf_res_t;

endpackage

// ===== rtl/lbf_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lbf_core
// Flasher state and its update for a tick, start or stop item.
// ---------------------------------------------------------------------------
module lbf_core
  import lbf_pkg::*;
#(
  parameter int TIME_BITS = LBF_TIME_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [CMD_W-1:0]   cmd,
  input  logic [COUNT_W-1:0] count,
  input  lbf_cfg_t           cfg,
  output lbf_res_t           res
);

  localparam int CMP_W = (TIME_BITS > CFG_TIME_W) ? TIME_BITS : CFG_TIME_W;
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  logic [TIME_BITS-1:0] elapsed, elapsed_next, elapsed_inc;
  logic [BURST_W-1:0]   flashes_left, flashes_left_next, flashes_dec;
  logic                 looping, looping_next;
  logic                 on_phase, on_phase_next;
  logic                 lit_out, lit_out_next;
  logic                 active;

  assign active      = (flashes_left != '0) || looping;
  assign elapsed_inc = (elapsed == TIME_MAX) ? elapsed : elapsed + 1'b1;
  assign flashes_dec = (flashes_left != '0) ? flashes_left - 1'b1 : flashes_left;

  always_comb begin
    elapsed_next      = elapsed;
    flashes_left_next = flashes_left;
    looping_next      = looping;
    on_phase_next     = on_phase;
    lit_out_next      = lit_out;
    unique case (cmd)
      CMD_TICK: begin
        if (cfg.enable && active) begin
          elapsed_next = elapsed_inc;
          if (on_phase) begin
            if (CMP_W'(elapsed_inc) > CMP_W'(cfg.on_time)) begin
              elapsed_next  = '0;
              on_phase_next = 1'b0;
            end else begin
              lit_out_next = 1'b1;
            end
          end else begin
            if (CMP_W'(elapsed_inc) > CMP_W'(cfg.dark_time)) begin
              flashes_left_next = flashes_dec;
              elapsed_next      = '0;
              if ((flashes_dec != '0) || looping) begin
                on_phase_next = 1'b1;
              end
            end else begin
              lit_out_next = 1'b0;
            end
          end
        end
      end
      CMD_START: begin
        if (flashes_left == '0) begin
          elapsed_next  = '0;
          on_phase_next = 1'b1;
          if (count > BURST_LIMIT) begin
            looping_next = 1'b1;
          end else begin
            flashes_left_next = count[BURST_W-1:0];
          end
        end
      end
      CMD_STOP: begin
        on_phase_next     = 1'b0;
        looping_next      = 1'b0;
        flashes_left_next = BURST_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed      <= '0;
      flashes_left <= '0;
      looping      <= 1'b0;
      on_phase     <= 1'b0;
      lit_out      <= 1'b0;
    end else if (step) begin
      elapsed      <= elapsed_next;
      flashes_left <= flashes_left_next;
      looping      <= looping_next;
      on_phase     <= on_phase_next;
      lit_out      <= lit_out_next;
    end
  end

  // result reflects the state after this item
  assign res.pin_level = lit_out_next ^ cfg.invert_output;
  assign res.lit       = lit_out_next;
  assign res.busy      = (flashes_left_next != '0) || looping_next;

endmodule

// ===== rtl/led_burst_flasher_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// led_burst_flasher_unit
// One LED channel flasher with burst count, endless loop and stop.
// ---------------------------------------------------------------------------
//
//  channel  direction  handshake          payload
//  -------  ---------  -----------------  --------------------------------
//  in       sink       in_valid/in_stall  command, flash_count
//  out      source     out_valid/out_stall pin_level, lit, busy_res
//  cfg      sink       cfg_write          cfg_index, cfg_data
//
//  One item per clock sustained while out_stall stays low. An accepted item
//  sits in the input register while the core updates on it, and its result
//  is loaded into the result register as the item steps, raising out_valid.
//  rst (synchronous) clears all flasher state and loads the register reset
//  values. A stalled result holds; the input register still takes one more
//  item behind it before in_stall rises.
//
module led_burst_flasher_unit
  import lbf_pkg::*;
#(
  parameter int TIME_BITS = LBF_TIME_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  // input items
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [CMD_W-1:0]       command,
  input  logic [COUNT_W-1:0]     flash_count,
  // result items
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   pin_level,
  output logic                   lit,
  output logic                   busy_res,
  // configuration
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // configuration registers
  lbf_cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.on_time       <= RESET_ON_TIME;
      cfg.dark_time     <= RESET_OFF_TIME;
      cfg.invert_output <= RESET_INVERT;
      cfg.enable        <= RESET_ENABLE;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ON_TIME:  cfg.on_time       <= cfg_data;
        REG_OFF_TIME: cfg.dark_time     <= cfg_data;
        REG_INVERT:   cfg.invert_output <= cfg_data[0];
        REG_ENABLE:   cfg.enable        <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // input register
  logic               in_q_valid;
  logic [CMD_W-1:0]   cmd_q;
  logic [COUNT_W-1:0] count_q;
  logic               in_accept;
  logic               advance;  // result register can take a new result
  logic               step;     // the held item is processed this cycle

  assign advance   = !out_valid || !out_stall;
  assign in_stall  = in_q_valid && !advance;
  assign in_accept = in_valid && !in_stall;
  assign step      = in_q_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_accept) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_q   <= command;
      count_q <= flash_count;
    end
  end

  // flasher state and update
  lbf_res_t res;

  lbf_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .step  (step),
    .cmd   (cmd_q),
    .count (count_q),
    .cfg   (cfg),
    .res   (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      pin_level <= res.pin_level;
      lit       <= res.lit;
      busy_res  <= res.busy;
    end
  end

  // checks
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (in_q_valid && out_valid && out_stall))
    else $error("input stalled while a stage is free");

  a_step_gives_result: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("processed item produced no result");

  a_stop_leaves_busy: assert property (@(posedge clk) disable iff (rst)
    (step && (cmd_q == CMD_STOP)) |=> busy_res)
    else $error("stop did not leave a final count");

  a_loop_start_busy: assert property (@(posedge clk) disable iff (rst)
    (step && (cmd_q == CMD_START) && (count_q > BURST_LIMIT)) |=> busy_res)
    else $error("endless start not reported busy");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LED burst flasher unit.
// A queue-fed driver offers tick, start, stop and spare commands. A built-in
// flasher model predicts pin level, lit and busy for every accepted item.
// A monitor checks each result in order. Register settings change between
// phases, and the phases use various mixes of sender gaps and receiver stalls.
// ---------------------------------------------------------------------------
module tb_top;
  import lbf_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE   = 2'd3;  // unused code, block ignores it
  localparam int               QUIET_LIMIT = 2000;  // cycles without any transfer
  localparam int               HOLD_CYCLES = 80;    // long receiver hold-off

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [COUNT_W-1:0] count;
  } flasher_cmd_t;

  // clock, reset and block inputs start at known values
  logic                   clk         = 1'b0;
  logic                   rst         = 1'b1;
  logic                   in_valid    = 1'b0;
  logic [CMD_W-1:0]       command     = CMD_TICK;
  logic [COUNT_W-1:0]     flash_count = '0;
  logic                   out_stall   = 1'b0;
  logic                   cfg_write   = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index   = REG_ON_TIME;
  logic [CFG_DATA_W-1:0]  cfg_data    = '0;

  logic in_stall;
  logic out_valid;
  logic pin_level;
  logic lit;
  logic busy_res;

  led_burst_flasher_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .flash_count(flash_count),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pin_level  (pin_level),
    .lit        (lit),
    .busy_res   (busy_res),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // -------------------------------------------------------------------------
  // Flasher model: register copy and channel state
  // -------------------------------------------------------------------------
  lbf_cfg_t                 flash_cfg;
  logic [LBF_TIME_BITS-1:0] elapsed;
  logic [BURST_W-1:0]       flashes_left;
  logic                     looping;
  logic                     on_phase;
  logic                     lit_now;

  // Applies one command to the model and returns the pin/lit/busy it leaves.
  function automatic lbf_res_t advance_flasher(input logic [CMD_W-1:0] cmd,
                                               input logic [COUNT_W-1:0] count);
    lbf_res_t res;
    case (cmd)
      CMD_TICK: begin
        // frozen when disabled or when nothing is left to flash
        if (flash_cfg.enable && (flashes_left != 0 || looping)) begin
          if (elapsed != '1) elapsed = elapsed + 1'b1;
          if (on_phase) begin
            if (elapsed > flash_cfg.on_time) begin
              elapsed  = '0;
              on_phase = 1'b0;
            end else begin
              lit_now = 1'b1;
            end
          end else begin
            if (elapsed > flash_cfg.dark_time) begin
              // end of one flash
              if (flashes_left != 0) flashes_left = flashes_left - 1'b1;
              elapsed = '0;
              if (flashes_left != 0 || looping) on_phase = 1'b1;
            end else begin
              lit_now = 1'b0;
            end
          end
        end
      end
      CMD_START: begin
        // refused while a burst count remains; taken while only looping
        if (flashes_left == 0) begin
          elapsed  = '0;
          on_phase = 1'b1;
          if (count > BURST_LIMIT) looping = 1'b1;
          else flashes_left = count[BURST_W-1:0];
        end
      end
      CMD_STOP: begin
        on_phase     = 1'b0;
        looping      = 1'b0;
        flashes_left = BURST_W'(1);  // one last off-phase before going idle
      end
      default: ;
    endcase
    res.pin_level = lit_now ^ flash_cfg.invert_output;
    res.lit       = lit_now;
    res.busy      = (flashes_left != 0) || looping;
    return res;
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus queue, expected results and bookkeeping
  // -------------------------------------------------------------------------
  flasher_cmd_t pending_cmds[$];
  lbf_res_t     expected_levels[$];
  int           n_queued      = 0;
  int           n_taken       = 0;
  int           mismatches    = 0;
  int           gap_pct       = 0;    // sender idle chance, percent
  int           stall_pct     = 0;    // receiver stall chance, percent
  logic         hold_req      = 1'b0; // ask the receiver for one long hold-off
  logic         hold_served   = 1'b0;
  int           hold_left     = 0;
  int           quiet_cycles  = 0;
  logic         in_fire       = 1'b0;

  // Driver: a new item only once the current one is taken, so valid never
  // follows stall and a waiting payload stays put.
  always @(negedge clk) begin
    flasher_cmd_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= gap_pct) begin
        nxt         = pending_cmds.pop_front();
        in_valid    <= 1'b1;
        command     <= nxt.cmd;
        flash_count <= nxt.count;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_req && !hold_served) begin
      hold_left   <= HOLD_CYCLES;
      hold_served <= 1'b1;
      out_stall   <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Monitor: predict on input transfer, check on output transfer
  always @(posedge clk) begin
    lbf_res_t want;
    in_fire = in_valid && !in_stall;
    if (!rst && in_fire) begin
      expected_levels.push_back(advance_flasher(command, flash_count));
      n_taken++;
    end
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_levels.size() == 0) begin
        $error("result item with nothing expected");
        mismatches++;
      end else begin
        want = expected_levels.pop_front();
        if (pin_level !== want.pin_level) begin
          $error("pin_level: expected %0d, got %0d", want.pin_level, pin_level);
          mismatches++;
        end
        if (lit !== want.lit) begin
          $error("lit: expected %0d, got %0d", want.lit, lit);
          mismatches++;
        end
        if (busy_res !== want.busy) begin
          $error("busy_res: expected %0d, got %0d", want.busy, busy_res);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Sequencing helpers
  // -------------------------------------------------------------------------
  task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input int count);
    flasher_cmd_t c;
    c.cmd   = cmd;
    c.count = count[COUNT_W-1:0];
    pending_cmds.push_back(c);
    n_queued++;
  endtask

  // Wait until every queued item is taken and every result checked.
  task automatic drain;
    while (n_taken != n_queued || expected_levels.size() != 0) @(posedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    case (idx)
      REG_ON_TIME:  flash_cfg.on_time       = value[CFG_TIME_W-1:0];
      REG_OFF_TIME: flash_cfg.dark_time     = value[CFG_TIME_W-1:0];
      REG_INVERT:   flash_cfg.invert_output = value[0];
      REG_ENABLE:   flash_cfg.enable        = value[0];
      default: ;
    endcase
  endtask

  // Block must be idle here: called only after drain or right after reset.
  task automatic set_config(input int on_t, input int off_t, input int inv, input int en);
    write_reg(REG_ON_TIME, on_t);
    write_reg(REG_OFF_TIME, off_t);
    write_reg(REG_INVERT, inv);
    write_reg(REG_ENABLE, en);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Mostly ticks so bursts run to completion; starts with short counts,
  // the loop threshold and full-range counts; some stops and spare codes.
  function automatic flasher_cmd_t random_cmd;
    flasher_cmd_t c;
    int           pick;
    pick = $urandom_range(99);
    if (pick < 72)      c.cmd = CMD_TICK;
    else if (pick < 86) c.cmd = CMD_START;
    else if (pick < 95) c.cmd = CMD_STOP;
    else                c.cmd = CMD_SPARE;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: c.count = COUNT_W'($urandom_range(4));
      6:                c.count = $urandom_range(1) ? BURST_LIMIT : BURST_LIMIT + 1'b1;
      7:                c.count = '1;
      default:          c.count = COUNT_W'($urandom_range(65535));
    endcase
    return c;
  endfunction

  task automatic random_phase(input int gap, input int stall, input int n_items);
    gap_pct   = gap;
    stall_pct = stall;
    repeat (n_items) begin
      pending_cmds.push_back(random_cmd());
      n_queued++;
    end
    drain();
  endtask

  // -------------------------------------------------------------------------
  // Test sequence
  // -------------------------------------------------------------------------
  initial begin
    flash_cfg.on_time       = RESET_ON_TIME;
    flash_cfg.dark_time     = RESET_OFF_TIME;
    flash_cfg.invert_output = RESET_INVERT;
    flash_cfg.enable        = RESET_ENABLE;
    elapsed      = '0;
    flashes_left = '0;
    looping      = 1'b0;
    on_phase     = 1'b0;
    lit_now      = 1'b0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings, flasher disabled: start handling and frozen ticks.
    queue_cmd(CMD_TICK, 0);
    queue_cmd(CMD_START, 0);        // zero count: on-phase but inactive
    queue_cmd(CMD_START, 3);        // taken, count loaded
    queue_cmd(CMD_START, 7);        // refused, count still pending
    queue_cmd(CMD_TICK, 0);         // disabled: nothing moves
    queue_cmd(CMD_TICK, 0);
    queue_cmd(CMD_SPARE, 16'hffff); // unused code leaves state alone
    queue_cmd(CMD_STOP, 0);         // forces one final off-phase
    queue_cmd(CMD_START, 16'hffff); // refused, final off-phase pending
    drain();

    // Enabled, short times, no inversion.
    set_config(1, 0, 0, 1);
    queue_cmd(CMD_TICK, 0);         // final off-phase ends, goes idle
    queue_cmd(CMD_TICK, 0);         // idle tick does nothing
    queue_cmd(CMD_START, 256);      // above the burst limit: endless loop
    repeat (6) queue_cmd(CMD_TICK, 0);
    queue_cmd(CMD_START, 2);        // taken while only looping
    repeat (3) queue_cmd(CMD_TICK, 0);
    queue_cmd(CMD_STOP, 0);
    repeat (3) queue_cmd(CMD_TICK, 0);
    queue_cmd(CMD_START, 255);      // largest plain burst count
    queue_cmd(CMD_TICK, 0);
    queue_cmd(CMD_STOP, 0);
    drain();

    // Random phases with different register settings and flow patterns.
    set_config(1, 2, 0, 1);
    random_phase(0, 0, 400);

    set_config(0, 0, 1, 1);
    random_phase(81, 0, 300);

    // Receiver stalls; one long hold-off fills the block while the
    // sender keeps offering.
    set_config(3, 1, 0, 1);
    hold_req = 1'b1;
    random_phase(0, 81, 300);

    set_config(65535, 0, 1, 1);
    random_phase(31, 31, 90);

    set_config(0, 65535, 0, 1);
    random_phase(31, 31, 90);

    set_config(2, 3, 1, 0);         // disabled: only starts and stops act
    random_phase(31, 31, 90);

    set_config($urandom_range(4), $urandom_range(4), $urandom_range(1), 1);
    random_phase(31, 31, 350);

    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_levels.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lbf_pkg.sv
rtl/lbf_core.sv
rtl/led_burst_flasher_unit.sv
test/tb_top.sv
